// ----- hdl/retargetable_eased_value_tween_macros.svh -----
// Assertion macros for the eased value tween checker.
// Depends on nothing; taken in by the checker file only.
`ifndef RETARGETABLE_EASED_VALUE_TWEEN_MACROS_SVH
`define RETARGETABLE_EASED_VALUE_TWEEN_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RVT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tween checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is held.
`define RVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tween checker: next-cycle property failed");

`endif

// ----- hdl/rvt_pkg.sv -----
// Shared constants for the eased value tween: widths, fixed-point format,
// retarget threshold. Used by the divider, the multiply unit and the top level.
package rvt_pkg;

    localparam int FRAC_BITS = 16;

    localparam int KEY_W  = 64;
    localparam int VAL_W  = 32;
    localparam int DUR_W  = 16;
    localparam int TIME_W = 32;
    localparam int DIFF_W = VAL_W + 1;
    localparam int EASE_W = FRAC_BITS + 1;
    localparam int MULB_W = EASE_W + 1;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);
    localparam int IN_W   = KEY_W + VAL_W + DUR_W + TIME_W;

    localparam logic [EASE_W-1:0]    ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS-1:0] HALF_FX = {1'b1, {(FRAC_BITS - 1){1'b0}}};
    localparam logic [EASE_W:0]      TWO_FX  = {1'b1, {(FRAC_BITS + 1){1'b0}}};

    // 0.001 rounded to nearest in the fixed-point format
    localparam int THRESH_INT = ((1 << FRAC_BITS) + 500) / 1000;
    localparam logic signed [DIFF_W-1:0] THRESH_FX     = DIFF_W'(THRESH_INT);
    localparam logic signed [DIFF_W-1:0] NEG_THRESH_FX = -DIFF_W'(THRESH_INT);

endpackage

// ----- hdl/retargetable_eased_value_tween.sv -----
// Top level of the retargetable eased value tween: request sequencer, held
// animation state, output register. Depends on rvt_pkg, rvt_div and rvt_mul.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------
//  s_       | in        | s_tvalid / s_tready    | s_tdata: key, target, duration, now
//  m_       | out       | m_tvalid / m_tready    | m_tdata: current_value
//  cfg_     | in        | cfg_valid / cfg_ready  | cfg_data: reduced_motion
//
// One request at a time. A snap (reduced motion, first request, new key) goes from
// EVAL to OUT; a finished or zero-length animation via RANGE and FINISH; a
// running one also via the bit-serial progress divider, SQR, CUBE, EASE,
// BLEND and SUM. s_tready returns at the same edge that loads the result. A
// result waiting on m_tready does not block the next request; only a second
// waits. Synchronous active-low reset clears FSM, mode, animation, m_tvalid.
module retargetable_eased_value_tween (
    input  logic                          aclk,
    input  logic                          aresetn,
    // lowest bit up: context_key[63:0], target_value[95:64],
    // duration[111:96], now_time[143:112]
    input  logic [rvt_pkg::IN_W-1:0]      s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // lowest bit up: current_value[31:0]
    output logic [rvt_pkg::VAL_W-1:0]     m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_EVAL   = 11'b000_0000_0010,
        ST_RANGE  = 11'b000_0000_0100,
        ST_DIV    = 11'b000_0000_1000,
        ST_SQR    = 11'b000_0001_0000,
        ST_CUBE   = 11'b000_0010_0000,
        ST_EASE   = 11'b000_0100_0000,
        ST_BLEND  = 11'b000_1000_0000,
        ST_SUM    = 11'b001_0000_0000,
        ST_FINISH = 11'b010_0000_0000,
        ST_OUT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic rm_reg, rm_next;

    // held animation state
    logic                                started_reg, started_next;
    logic [rvt_pkg::KEY_W-1:0]           ctx_reg, ctx_next;
    logic [rvt_pkg::TIME_W-1:0]          t0_reg, t0_next;
    logic [rvt_pkg::DUR_W-1:0]           dur_reg, dur_next;
    logic signed [rvt_pkg::VAL_W-1:0]    from_reg, from_next;
    logic signed [rvt_pkg::VAL_W-1:0]    goal_reg, goal_next;

    // latched request
    logic [rvt_pkg::KEY_W-1:0]           rq_key_reg, rq_key_next;
    logic signed [rvt_pkg::VAL_W-1:0]    rq_tgt_reg, rq_tgt_next;
    logic [rvt_pkg::DUR_W-1:0]           rq_dur_reg, rq_dur_next;
    logic [rvt_pkg::TIME_W-1:0]          rq_now_reg, rq_now_next;

    // working values
    logic                                retgt_reg, retgt_next;
    logic [rvt_pkg::TIME_W-1:0]          elap_reg, elap_next;
    logic [rvt_pkg::EASE_W-1:0]          x_reg, x_next;
    logic                                upper_reg, upper_next;
    logic [rvt_pkg::EASE_W-1:0]          eased_reg, eased_next;
    logic signed [rvt_pkg::VAL_W-1:0]    val_reg, val_next;

    // output register
    logic [rvt_pkg::VAL_W-1:0]           out_reg, out_next;
    logic                                ovld_reg, ovld_next;

    // shared units
    logic                                div_start;
    logic [rvt_pkg::FRAC_BITS-1:0]       div_quot;
    logic                                div_done;
    logic signed [rvt_pkg::DIFF_W-1:0]   mul_a;
    logic signed [rvt_pkg::MULB_W-1:0]   mul_b;
    logic signed [rvt_pkg::DIFF_W-1:0]   mul_p;

    // combinational helpers
    logic                                accept;
    logic                                snap;
    logic signed [rvt_pkg::DIFF_W-1:0]   tgt_diff;
    logic signed [rvt_pkg::DIFF_W-1:0]   span;
    logic [rvt_pkg::EASE_W:0]            mirror;
    logic signed [rvt_pkg::DIFF_W-1:0]   blend_sum;
    logic [rvt_pkg::EASE_W-1:0]          half_q3;

    rvt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (elap_reg[rvt_pkg::DUR_W-1:0]),
        .divisor  (dur_reg),
        .quot     (div_quot),
        .done     (div_done)
    );

    rvt_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    assign snap      = rm_reg || !started_reg || (rq_key_reg != ctx_reg);
    assign tgt_diff  = rvt_pkg::DIFF_W'(goal_reg) - rvt_pkg::DIFF_W'(rq_tgt_reg);
    assign span      = rvt_pkg::DIFF_W'(goal_reg) - rvt_pkg::DIFF_W'(from_reg);
    // progress reflected about 1 for the second half of the curve: 2 - 2p
    assign mirror    = rvt_pkg::TWO_FX - {1'b0, div_quot, 1'b0};
    assign blend_sum = rvt_pkg::DIFF_W'(from_reg) + mul_p;
    assign half_q3   = mul_p[rvt_pkg::EASE_W:1];

    // feed the shared multiplier from the current step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQR: begin
                mul_a = rvt_pkg::DIFF_W'(x_reg);
                mul_b = {1'b0, x_reg};
            end
            ST_CUBE: begin
                mul_a = mul_p;
                mul_b = {1'b0, x_reg};
            end
            ST_BLEND: begin
                mul_a = span;
                mul_b = {1'b0, eased_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        rm_next      = cfg_valid ? cfg_data : rm_reg;
        started_next = started_reg;
        ctx_next     = ctx_reg;
        t0_next      = t0_reg;
        dur_next     = dur_reg;
        from_next    = from_reg;
        goal_next    = goal_reg;
        rq_key_next  = rq_key_reg;
        rq_tgt_next  = rq_tgt_reg;
        rq_dur_next  = rq_dur_reg;
        rq_now_next  = rq_now_reg;
        retgt_next   = retgt_reg;
        elap_next    = elap_reg;
        x_next       = x_reg;
        upper_next   = upper_reg;
        eased_next   = eased_reg;
        val_next     = val_reg;
        out_next     = out_reg;
        ovld_next    = ovld_reg && !m_tready;
        div_start    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    rq_key_next = s_tdata[rvt_pkg::KEY_W-1:0];
                    rq_tgt_next = s_tdata[rvt_pkg::KEY_W +: rvt_pkg::VAL_W];
                    rq_dur_next = s_tdata[rvt_pkg::KEY_W + rvt_pkg::VAL_W +: rvt_pkg::DUR_W];
                    rq_now_next = s_tdata[rvt_pkg::IN_W-1 -: rvt_pkg::TIME_W];
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (snap) begin
                    // jump straight to the target and restart the animation there
                    started_next = 1'b1;
                    ctx_next     = rq_key_reg;
                    t0_next      = rq_now_reg;
                    dur_next     = rm_reg ? '0 : rq_dur_reg;
                    from_next    = rq_tgt_reg;
                    goal_next    = rq_tgt_reg;
                    val_next     = rq_tgt_reg;
                    state_next   = ST_OUT;
                end else begin
                    retgt_next = (tgt_diff > rvt_pkg::THRESH_FX) ||
                                 (tgt_diff < rvt_pkg::NEG_THRESH_FX);
                    elap_next  = (rq_now_reg > t0_reg) ? (rq_now_reg - t0_reg) : '0;
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE: begin
                // zero length or time past the end: hold at the goal
                if ((dur_reg == '0) ||
                    (elap_reg >= rvt_pkg::TIME_W'(dur_reg))) begin
                    val_next   = goal_reg;
                    state_next = ST_FINISH;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    upper_next = (div_quot >= rvt_pkg::HALF_FX);
                    x_next     = (div_quot >= rvt_pkg::HALF_FX) ?
                                 mirror[rvt_pkg::EASE_W-1:0] :
                                 {1'b0, div_quot};
                    state_next = ST_SQR;
                end
            end
            ST_SQR: begin
                state_next = ST_CUBE;
            end
            ST_CUBE: begin
                state_next = ST_EASE;
            end
            ST_EASE: begin
                // ease-in half: 4 t^3; ease-out half: 1 - q^3 / 2
                eased_next = upper_reg ? (rvt_pkg::ONE_FX - half_q3) :
                             {mul_p[rvt_pkg::EASE_W-3:0], 2'b00};
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                val_next   = blend_sum[rvt_pkg::VAL_W-1:0];
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // retarget: restart from the value shown now toward the new goal
                if (retgt_reg) begin
                    from_next = val_reg;
                    goal_next = rq_tgt_reg;
                    t0_next   = rq_now_reg;
                    dur_next  = rq_dur_reg;
                    if (rq_dur_reg == '0) begin
                        val_next = rq_tgt_reg;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!ovld_reg || m_tready) begin
                    out_next   = val_reg;
                    ovld_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rm_reg      <= 1'b0;
            started_reg <= 1'b0;
            ctx_reg     <= '0;
            t0_reg      <= '0;
            dur_reg     <= '0;
            from_reg    <= '0;
            goal_reg    <= '0;
            ovld_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rm_reg      <= rm_next;
            started_reg <= started_next;
            ctx_reg     <= ctx_next;
            t0_reg      <= t0_next;
            dur_reg     <= dur_next;
            from_reg    <= from_next;
            goal_reg    <= goal_next;
            ovld_reg    <= ovld_next;
        end
        rq_key_reg <= rq_key_next;
        rq_tgt_reg <= rq_tgt_next;
        rq_dur_reg <= rq_dur_next;
        rq_now_reg <= rq_now_next;
        retgt_reg  <= retgt_next;
        elap_reg   <= elap_next;
        x_reg      <= x_next;
        upper_reg  <= upper_next;
        eased_reg  <= eased_next;
        val_reg    <= val_next;
        out_reg    <= out_next;
    end

    assign m_tdata  = out_reg;
    assign m_tvalid = ovld_reg;

endmodule

// ----- hdl/rvt_div.sv -----
// Bit-serial restoring divider: floor(dividend * 2^FRAC_BITS / divisor), one
// quotient bit per cycle. Requires dividend < divisor. Depends on rvt_pkg.
module rvt_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [rvt_pkg::DUR_W-1:0]           dividend,
    input  logic [rvt_pkg::DUR_W-1:0]           divisor,
    output logic [rvt_pkg::FRAC_BITS-1:0]       quot,
    output logic                                done
);

    logic [rvt_pkg::DUR_W-1:0]     rem_reg, rem_next;
    logic [rvt_pkg::DUR_W-1:0]     dvs_reg, dvs_next;
    logic [rvt_pkg::FRAC_BITS-1:0] quot_reg, quot_next;
    logic [rvt_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [rvt_pkg::DUR_W:0]       rem_dbl;
    logic [rvt_pkg::DUR_W:0]       rem_sub;
    logic                          fits;

    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_sub = rem_dbl - {1'b0, dvs_reg};
    assign fits    = rem_dbl >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            dvs_next  = divisor;
            quot_next = '0;
            cnt_next  = rvt_pkg::CNT_W'(rvt_pkg::FRAC_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? rem_sub[rvt_pkg::DUR_W-1:0] : rem_dbl[rvt_pkg::DUR_W-1:0];
            quot_next = {quot_reg[rvt_pkg::FRAC_BITS-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == rvt_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

// ----- hdl/rvt_mul.sv -----
// Shared signed multiply and fixed-point rescale: floor(a * b / 2^FRAC_BITS),
// registered. Used for squaring, cubing and the final blend. Depends on rvt_pkg.
module rvt_mul (
    input  logic                                  aclk,
    input  logic signed [rvt_pkg::DIFF_W-1:0]     op_a,
    input  logic signed [rvt_pkg::MULB_W-1:0]     op_b,
    output logic signed [rvt_pkg::DIFF_W-1:0]     prod
);

    localparam int PROD_W = rvt_pkg::DIFF_W + rvt_pkg::MULB_W;

    logic signed [PROD_W-1:0]         full;
    logic signed [PROD_W-1:0]         scaled;
    logic signed [rvt_pkg::DIFF_W-1:0] prod_reg, prod_next;

    // arithmetic shift gives floor for negative products too
    assign full      = PROD_W'(op_a) * PROD_W'(op_b);
    assign scaled    = full >>> rvt_pkg::FRAC_BITS;
    assign prod_next = scaled[rvt_pkg::DIFF_W-1:0];

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- hdl/rvt_chk.sv -----
// Port-level checker for the eased value tween, bound to the top level.
// Depends on rvt_pkg and retargetable_eased_value_tween_macros.svh.
`include "retargetable_eased_value_tween_macros.svh"

module rvt_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [rvt_pkg::VAL_W-1:0]     m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    // one request at a time: ready drops after every accepted request
    `RVT_ASSERT_NEXT(a_busy_after_req, aclk, aresetn, s_acc, !s_tready)

    // no result appears in the cycle right after a request
    `RVT_ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_acc, !$rose(m_tvalid))

    // a new result only comes out of a busy sequencer
    `RVT_ASSERT_NOW(a_result_from_work, aclk, aresetn, $rose(m_tvalid), $past(!s_tready))

    // a stalled result holds
    `RVT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind retargetable_eased_value_tween rvt_chk u_rvt_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ----- bench/retargetable_eased_value_tween_tb.sv -----
// Self-checking bench for the retargetable eased value tween: directed corner
// requests, then random animation tracks, checked against a built-in predictor.
// Depends on rvt_pkg and the retargetable_eased_value_tween top level.
module retargetable_eased_value_tween_tb;

    localparam int     KEY_W  = rvt_pkg::KEY_W;
    localparam int     VAL_W  = rvt_pkg::VAL_W;
    localparam int     DUR_W  = rvt_pkg::DUR_W;
    localparam int     TIME_W = rvt_pkg::TIME_W;
    localparam int     IN_W   = rvt_pkg::IN_W;
    localparam int     FB     = rvt_pkg::FRAC_BITS;
    localparam longint ONE_V  = longint'(1) << FB;
    localparam longint HALF_V = longint'(1) << (FB - 1);
    // 0.001 in the fixed-point format, rounded to nearest
    localparam int     TH     = ((1 << FB) + 500) / 1000;

    // Request layout, lowest bit up: key, target, duration, now
    typedef struct packed {
        logic [TIME_W-1:0]       now;
        logic [DUR_W-1:0]        dur;
        logic signed [VAL_W-1:0] target;
        logic [KEY_W-1:0]        key;
    } tween_req_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic [IN_W-1:0]     s_tdata   = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [VAL_W-1:0]    m_tdata;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data  = 1'b0;

    retargetable_eased_value_tween u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Run-length guard: far above the slowest legal run.
    initial begin
        #2000000;
        $display("timeout: requests or results stopped moving");
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    tween_req_t       pending_requests[$];   // requests waiting for the driver
    logic [VAL_W-1:0] expected_values[$];    // predicted results, oldest first
    int               queued_total   = 0;
    int               accepted_total = 0;
    int               checked_total  = 0;
    int               error_count    = 0;
    int               snap_count     = 0;
    int               retarget_count = 0;
    int               mid_count      = 0;
    int               motion_count   = 0;
    bit               quiet          = 1'b0; // no idling on either side
    logic             req_fire       = 1'b0;
    logic             cfg_fire       = 1'b0;

    // Predictor copy of the animation state and the register
    bit                motion_on  = 1'b0;
    bit                tw_started = 1'b0;
    logic [KEY_W-1:0]  tw_key     = '0;
    logic [TIME_W-1:0] tw_start   = '0;
    logic [DUR_W-1:0]  tw_dur     = '0;
    longint            tw_from    = 0;
    longint            tw_goal    = 0;
    bit                last_mid   = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint cubic_ease(input longint p);
        longint t2, t3, q, q2, q3;
        if (p < HALF_V) begin
            t2 = (p * p) >>> FB;
            t3 = (t2 * p) >>> FB;
            return 4 * t3;
        end
        q  = 2 * ONE_V - 2 * p;
        q2 = (q * q) >>> FB;
        q3 = (q2 * q) >>> FB;
        return ONE_V - (q3 >>> 1);
    endfunction

    // Value shown at the given time by the held animation.
    function automatic longint value_at(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        longint            p;
        last_mid = 1'b0;
        if (!tw_started)
            return 0;
        if (tw_dur == 0)
            return tw_goal;
        // clamp at zero when the clock reads earlier than the start
        elapsed = (now > tw_start) ? now - tw_start : '0;
        if (elapsed >= tw_dur)
            return tw_goal;
        last_mid = 1'b1;
        p = (longint'(elapsed) << FB) / longint'(tw_dur);
        // arithmetic shift floors negative products as well
        return tw_from + (((tw_goal - tw_from) * cubic_ease(p)) >>> FB);
    endfunction

    function automatic void snap_to(input logic [KEY_W-1:0] k, input longint v,
                                    input logic [DUR_W-1:0] d,
                                    input logic [TIME_W-1:0] now);
        tw_started = 1'b1;
        tw_key     = k;
        tw_start   = now;
        tw_dur     = d;
        tw_from    = v;
        tw_goal    = v;
        snap_count++;
    endfunction

    // Advance the predicted state by one request and return its result.
    function automatic logic [VAL_W-1:0] tween_step(input tween_req_t r);
        longint tgt, diff, shown;
        tgt = longint'(r.target);
        if (motion_on) begin
            motion_count++;
            snap_to(r.key, tgt, '0, r.now);
            return r.target;
        end
        if (!tw_started || tw_key != r.key) begin
            snap_to(r.key, tgt, r.dur, r.now);
            return r.target;
        end
        diff = tw_goal - tgt;
        if (diff < 0)
            diff = -diff;
        // a move beyond the threshold restarts from what is on screen now
        if (diff > longint'(TH)) begin
            retarget_count++;
            shown    = value_at(r.now);
            tw_from  = shown;
            tw_goal  = tgt;
            tw_start = r.now;
            tw_dur   = r.dur;
        end
        shown = value_at(r.now);
        if (last_mid)
            mid_count++;
        return VAL_W'(shown);
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("MISMATCH at %0t: %s (got %h, want %h)", $realtime, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. Check the outgoing
    // result before predicting the incoming request so a same-edge pair
    // never pairs up wrongly.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [VAL_W-1:0] want;
        req_fire <= aresetn && s_tvalid && s_tready;
        cfg_fire <= aresetn && cfg_valid && cfg_ready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                checked_total++;
                if (expected_values.size() == 0) begin
                    report_mismatch("result with no request outstanding", m_tdata, 'x);
                end else begin
                    want = expected_values.pop_front();
                    if (m_tdata !== want)
                        report_mismatch("current_value", m_tdata, want);
                end
            end
            if (cfg_valid && cfg_ready)
                motion_on = cfg_data;
            if (s_tvalid && s_tready) begin
                accepted_total++;
                expected_values.push_back(tween_step(tween_req_t'(s_tdata)));
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (quiet)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: change inputs on the falling edge; hold the request
    // until it is taken, then idle for a random gap.
    // ------------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_fire) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                s_tdata  <= pending_requests.pop_front();
                s_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls on m_tready.
    int unsigned stall_left = 0;

    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(99) < 25)
                stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_req(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v,
                            input logic [DUR_W-1:0] d, input logic [TIME_W-1:0] now);
        tween_req_t r;
        r.key    = k;
        r.target = v;
        r.dur    = d;
        r.now    = now;
        pending_requests.push_back(r);
        queued_total++;
    endtask

    // Hold until every queued request is taken and every result is back.
    task automatic drain();
        while (accepted_total != queued_total || expected_values.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_motion(input bit v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge aclk); while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [DUR_W-1:0] pick_dur();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return DUR_W'($urandom_range(400, 1));
        if (roll < 75)
            return DUR_W'($urandom_range(3, 0));
        return DUR_W'($urandom_range(65535, 0));
    endfunction

    // Current animation track for the random part
    logic [KEY_W-1:0]        trk_key    = '0;
    logic [TIME_W-1:0]       trk_now    = '0;
    logic [DUR_W-1:0]        trk_dur    = 16'd100;
    logic signed [VAL_W-1:0] trk_target = '0;

    // Mostly coherent tracks: one key, a clock that moves forward, targets
    // that hold, nudge or jump. A few requests are pure noise.
    task automatic queue_random(input int count);
        int unsigned roll;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                push_req({$urandom, $urandom}, $urandom, DUR_W'($urandom), $urandom);
            end else begin
                if (roll < 12) begin
                    trk_key    = (roll < 9) ? KEY_W'($urandom_range(3)) : {$urandom, $urandom};
                    trk_now    = $urandom;
                    trk_dur    = pick_dur();
                    trk_target = $urandom;
                end else begin
                    roll = $urandom_range(99);
                    if (roll < 5)
                        trk_now = trk_now - $urandom_range(200, 1);
                    else
                        trk_now = trk_now + $urandom_range(int'(trk_dur) / 3 + 1, 0);
                    roll = $urandom_range(99);
                    if (roll < 15) begin
                        trk_target = trk_target + int'($urandom_range(2 * TH, 0)) - TH;
                    end else if (roll < 20) begin
                        trk_target = trk_target + ($urandom_range(1) ? TH + 1 : -(TH + 1));
                    end else if (roll < 50) begin
                        trk_target = $urandom_range(1) ? VAL_W'($urandom)
                                   : trk_target + int'($urandom_range(1 << 21, 0)) - (1 << 20);
                        if ($urandom_range(99) < 30)
                            trk_dur = pick_dur();
                    end
                end
                push_req(trk_key, trk_target, trk_dur, trk_now);
            end
        end
    endtask

    localparam logic [VAL_W-1:0] VMAX = {1'b0, {(VAL_W - 1){1'b1}}};
    localparam logic [VAL_W-1:0] VMIN = {1'b1, {(VAL_W - 1){1'b0}}};
    localparam logic [KEY_W-1:0] KEY_A = {(KEY_W / 2){2'b01}};
    localparam logic [KEY_W-1:0] KEY_B = {(KEY_W / 2){2'b10}};

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        write_motion(1'b0);

        // First request on key 0 snaps even though the held key is 0 too.
        push_req('0, VMAX, 16'hFFFF, 32'd0);
        // Full-range retarget, then reads before start, below, at and past half.
        push_req('0, VMIN, 16'd100, 32'd10);
        push_req('0, VMIN, 16'd100, 32'd5);
        push_req('0, VMIN, 16'd100, 32'd35);
        push_req('0, VMIN, 16'd100, 32'd60);
        push_req('0, VMIN, 16'd100, 32'd85);
        // Nudge by exactly the threshold keeps the animation; one more restarts.
        push_req('0, VMIN + TH, 16'd100, 32'd90);
        push_req('0, VMIN + TH + 1, 16'd100, 32'd95);
        push_req('0, VMIN + TH + 1, 16'd100, 32'd200);
        // Zero duration lands on the goal at once.
        push_req('0, '0, 16'd0, 32'd201);
        // New key at the top of the clock, then a clock that wraps to zero.
        push_req('1, '1, 16'd1, '1);
        push_req('1, 32'h0001_0000, 16'hFFFF, '1);
        push_req('1, 32'h0001_0000, 16'hFFFF, 32'd0);
        // Longest duration swept across the ease curve.
        push_req(KEY_A, VMAX, 16'hFFFF, 32'd1000);
        push_req(KEY_A, VMIN, 16'hFFFF, 32'd1000);
        push_req(KEY_A, VMIN, 16'hFFFF, 32'd1000 + 32767);
        push_req(KEY_A, VMIN, 16'hFFFF, 32'd1000 + 32768);
        push_req(KEY_A, VMIN, 16'hFFFF, 32'd1000 + 65534);
        push_req(KEY_A, VMIN, 16'hFFFF, 32'd1000 + 65535);
        push_req(KEY_B, 32'd12345, 16'd50, 32'd7);
        drain();

        // Reduced motion snaps even on the running key.
        write_motion(1'b1);
        push_req(KEY_B, -(32'd5 << FB), 16'd500, 32'd8);
        push_req(KEY_B, VMAX, 16'd500, 32'd9);
        drain();
        write_motion(1'b0);
        // Back to normal motion: the held zero duration gives the goal first.
        push_req(KEY_B, '0, 16'd300, 32'd10);
        push_req(KEY_B, '0, 16'd300, 32'd160);
        drain();

        queue_random(900);
        drain();

        write_motion(1'b1);
        queue_random(150);
        drain();
        write_motion(1'b0);

        // A stretch with no idling on either side.
        quiet = 1'b1;
        queue_random(300);
        drain();
        quiet = 1'b0;

        queue_random(650);
        drain();

        // Let any stray result surface before closing.
        repeat (40) @(posedge aclk);
        if (expected_values.size() != 0)
            report_mismatch("results never arrived", '0, expected_values[0]);

        $display("covered %0d requests and %0d results: %0d snaps, %0d retargets,",
                 accepted_total, checked_total, snap_count, retarget_count);
        $display("  %0d mid-animation values, %0d requests under reduced motion",
                 mid_count, motion_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
